@@ src/cq_pkg.sv @@
// Package for the compacting queue: beat structs, action and status codes.
// Used by every module of the block; depends on nothing else.
package cq_pkg;

    // Fixed field widths of the request and result beats.
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned COUNT_W = 8;

    // Action codes; the fourth code means nothing and is rejected.
    localparam logic [ACT_W-1:0] ACT_APPEND      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE_AT   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND_REMOVE = 2'd2;

    // Status codes of a result.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    typedef logic signed [WORD_W-1:0] word_t;

    // One request beat.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        word_t            value;
        logic [POS_W-1:0] position;
    } cq_req_t;

    // One result beat.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        word_t              removed_value;
        logic [POS_W-1:0]   removed_position;
        logic [COUNT_W-1:0] entry_count;
    } cq_rsp_t;

    // Control that the sequencer broadcasts to every cell.
    typedef struct packed {
        logic rotate;   // every cell but a kept tail takes its upper neighbor's word
        logic keep;     // the head word wraps around to the tail cell
        logic append;   // the selected cell loads the appended word
    } cq_cell_ctl_t;

endpackage

@@ src/cq_cell.sv @@
// One storage cell of the queue chain: holds a single word.
// Depends on cq_pkg for the word type and the broadcast control struct.
module cq_cell #(
    parameter int unsigned CNT_W = 8,
    parameter int unsigned INDEX = 0
) (
    input  logic                 clk,
    input  cq_pkg::cq_cell_ctl_t ctl,
    input  logic [CNT_W-1:0]     sel_idx,
    input  cq_pkg::word_t        head_word,
    input  cq_pkg::word_t        nbr_word,
    input  cq_pkg::word_t        app_word,
    output cq_pkg::word_t        word
);
    import cq_pkg::*;

    word_t word_reg;
    word_t word_next;
    logic  is_sel;

    // This cell is the tail during a rotation, or the free slot on an append.
    assign is_sel = (sel_idx == CNT_W'(INDEX));

    // During a rotation the word moves one cell toward the head; the tail cell
    // takes the old head word unless that word is being dropped.
    always_comb
    begin
        word_next = word_reg;
        if (ctl.rotate)
        begin
            word_next = (ctl.keep && is_sel) ? head_word : nbr_word;
        end
        else if (ctl.append && is_sel)
        begin
            word_next = app_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

@@ src/compacting_queue_with_delete.sv @@
// Top level of the compacting queue: request sequencer and the chain of cells.
// Depends on cq_pkg and instantiates cq_cell once per entry.
//
// A request is taken when start is high and busy is low. An append, and any
// request that is rejected at once (full, bad position, empty queue, unused
// action), gives its result in the cycle after it was taken. A removal, by
// position or by search, rotates the whole queue once through the head cell,
// where a single comparator looks at one entry per cycle: it keeps busy high
// until every entry has passed the head cell, and the result follows in the
// next cycle, when busy is low again and a new request can be taken. Each
// result is shown for exactly one cycle with done high; the receiver cannot
// stall it and must take it then.
module compacting_queue_with_delete #(
    parameter int unsigned DEPTH = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cq_pkg::cq_req_t req,
    output logic            busy,
    output logic            done,
    output cq_pkg::cq_rsp_t rsp
);
    import cq_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_ROT  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic             found_reg, found_next;
    logic             done_reg, done_next;
    cq_req_t          req_reg, req_next;
    cq_rsp_t          rsp_reg, rsp_next;

    cq_cell_ctl_t     ctl;
    logic [CNT_W-1:0] sel_idx;
    word_t            cell_word [DEPTH];
    word_t            head_word;
    logic             hit;

    assign head_word = cell_word[0];

    // Chain of cells; the top cell wraps to the head word.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t nbr;
        if (i == DEPTH - 1)
        begin : g_top
            assign nbr = cell_word[0];
        end
        else
        begin : g_mid
            assign nbr = cell_word[i + 1];
        end
        cq_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .sel_idx   (sel_idx),
            .head_word (head_word),
            .nbr_word  (nbr),
            .app_word  (req.value),
            .word      (cell_word[i])
        );
    end

    // The head entry is the one to drop: first match on a search, or the
    // entry whose original index equals the requested position.
    always_comb
    begin
        hit = 1'b0;
        if (!found_reg)
        begin
            if (req_reg.action == ACT_FIND_REMOVE)
            begin
                hit = (head_word == req_reg.value);
            end
            else
            begin
                hit = (CMP_W'(step_reg) == CMP_W'(req_reg.position));
            end
        end
    end

    // Request sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        found_next = found_reg;
        done_next  = 1'b0;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        ctl        = '0;
        sel_idx    = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next                  = req;
                    rsp_next.removed_value    = '0;
                    rsp_next.removed_position = '0;
                    rsp_next.entry_count      = COUNT_W'(cnt_reg);
                    rsp_next.status           = ST_OK;
                    unique case (req.action)
                        ACT_APPEND:
                        begin
                            done_next = 1'b1;
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                ctl.append           = 1'b1;
                                cnt_next             = cnt_reg + CNT_W'(1);
                                rsp_next.entry_count = COUNT_W'(cnt_next);
                            end
                        end
                        ACT_REMOVE_AT:
                        begin
                            if (CMP_W'(req.position) >= CMP_W'(cnt_reg))
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                state_next = S_ROT;
                                rem_next   = cnt_reg;
                                step_next  = '0;
                                found_next = 1'b0;
                            end
                        end
                        ACT_FIND_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_ROT;
                                rem_next   = cnt_reg;
                                step_next  = '0;
                                found_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_ROT:
            begin
                // One rotation step; a dropped head shrinks the ring by one.
                ctl.rotate = 1'b1;
                ctl.keep   = !hit;
                sel_idx    = cnt_reg - CNT_W'(1);
                step_next  = step_reg + CNT_W'(1);
                rem_next   = rem_reg - CNT_W'(1);
                if (hit)
                begin
                    cnt_next                  = cnt_reg - CNT_W'(1);
                    found_next                = 1'b1;
                    rsp_next.removed_value    = head_word;
                    rsp_next.removed_position = POS_W'(step_reg);
                end
                if (rem_reg == CNT_W'(1))
                begin
                    state_next           = S_IDLE;
                    done_next            = 1'b1;
                    rsp_next.entry_count = COUNT_W'(cnt_next);
                    rsp_next.status      = found_next ? ST_OK : ST_NOTFOUND;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            step_reg  <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            step_reg  <= step_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers: the held request and the result beat.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg == S_ROT);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // A result beat is only ever shown once the sequencer is idle again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat shown while a rotation is still running");

    // The entry count never exceeds the queue depth.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // A rotation always has steps left to run.
    a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> rem_reg != '0)
        else $error("rotation running with no steps left");

    // The reported count matches the count the queue now holds.
    a_count_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.entry_count == COUNT_W'(cnt_reg))
        else $error("reported entry count disagrees with queue state");

    // A removal by position always finds its entry before the rotation ends.
    a_pos_found: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && req_reg.action == ACT_REMOVE_AT && rem_reg == CNT_W'(1))
            |=> done && rsp.status == ST_OK)
        else $error("removal by position ended without removing an entry");

endmodule
